[rtl/rtpe_pkg.sv]
`default_nettype none

package rtpe_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CH_W        = 5;
  localparam int unsigned COLOR_W     = 15;
  localparam int unsigned SLOT_W      = 4;
  localparam int unsigned PIX_W       = 4;
  localparam int unsigned PLANES      = 4;
  localparam int unsigned ROWS        = 8;
  localparam int unsigned ROW_W       = 3;
  localparam int unsigned COL_W       = 3;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned BEATS_LAST  = 2 + 2 * ROWS;
  localparam int unsigned BEAT_W      = $clog2(BEATS_LAST);

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [1:0] {
    CMD_ROW,
    CMD_ROW_LAST,
    CMD_QUERY,
    CMD_OVF
  } cmd_e;

  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } bk_state_e;

  typedef struct packed {
    logic                kind;
    logic [BYTE_W-1:0]   data_byte;
    logic [SLOT_W-1:0]   palette_slot;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   out_byte;
    logic                out_last;
    logic [COLOR_W-1:0]  palette_color;
    logic                palette_valid;
    logic                color_overflow;
  } out_item_t;

  // one command handed from the classifier to the emitter
  typedef struct packed {
    cmd_e                           cmd;
    logic [ROW_W-1:0]               row;
    logic [PLANES-1:0][BYTE_W-1:0]  planes;
    logic [COLOR_W-1:0]             color;
    logic                           valid;
    logic                           ovf;
  } qent_t;

endpackage

`default_nettype wire

[rtl/rgb_tile_planar_encoder.sv]
`default_nettype none

// 4bpp planar tile encoder. Pixel bytes arrive red, green, blue; each color
// is mapped to a palette slot (first-seen order) and shifted into the current
// 8-pixel row. The front stage takes one input beat per clock while its
// two-entry command queue has room, so pixel bytes and palette queries enter
// at one per cycle. The back stage pulls a command while idle, then emits
// its output beats: a row end gives 2 beats, a tile end 18 beats, a query
// or overflow report one beat. With 24 input bytes per row the queue hides
// the back stage's work, and a pixel stream runs at one byte per clock when
// the output side is always ready. Once the palette overflows, pixel bytes
// are dropped until reset; queries still answer.
module rgb_tile_planar_encoder import rtpe_pkg::*; #(
  parameter int unsigned PALETTE_ENTRIES = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output out_item_t     out_data_o
);

  logic  q_push, q_full, q_pop, q_empty;
  qent_t q_wdata, q_rdata;

  rtpe_front #(
    .PAL_ENTRIES(PALETTE_ENTRIES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .full_i      (q_full),
    .push_o      (q_push),
    .push_data_o (q_wdata)
  );

  rtpe_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata),
    .empty_o     (q_empty)
  );

  rtpe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .pop_data_i  (q_rdata),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

[rtl/rtpe_front.sv]
`default_nettype none

module rtpe_front import rtpe_pkg::*; #(
  parameter int unsigned PAL_ENTRIES = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_data_i,
  input  wire logic     full_i,
  output logic          push_o,
  output qent_t         push_data_o
);

  localparam int unsigned IDX_W  = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;
  localparam int unsigned FILL_W = $clog2(PAL_ENTRIES + 1);

  logic [1:0]                    ch_q, ch_d;
  logic [1:0][CH_W-1:0]          held_q;
  logic                          held_we;
  logic [COLOR_W-1:0]            pal_color_q [PAL_ENTRIES];
  logic [PAL_ENTRIES-1:0]        pal_used_q;
  logic [FILL_W-1:0]             fill_q, fill_d;
  logic [COL_W-1:0]              col_q, col_d;
  logic [ROW_W-1:0]              row_q, row_d;
  logic                          ovf_q, ovf_d;
  logic [PLANES-1:0][BYTE_W-1:0] plane_q, plane_d;

  logic                          accept;
  logic [CH_W-1:0]               chan5;
  logic [COLOR_W-1:0]            color;
  logic [PAL_ENTRIES-1:0]        hit;
  logic                          found;
  logic [IDX_W-1:0]              hit_idx;
  logic [IDX_W-1:0]              pal_widx;
  logic                          pal_we;
  logic                          pal_full;
  logic [IDX_W-1:0]              q_idx;
  logic                          q_valid;
  logic [COLOR_W-1:0]            q_color;
  logic [PIX_W-1:0]              pix;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign chan5      = in_data_i.data_byte[BYTE_W-1 -: CH_W];
  assign color      = {chan5, held_q[1], held_q[0]};
  assign pal_widx   = fill_q[IDX_W-1:0];
  assign pal_full   = (fill_q == FILL_W'(PAL_ENTRIES));

  assign q_idx   = in_data_i.palette_slot[IDX_W-1:0];
  assign q_valid = (int'(in_data_i.palette_slot) < PAL_ENTRIES) && pal_used_q[q_idx];
  assign q_color = q_valid ? pal_color_q[q_idx] : '0;

  always_comb begin
    for (int i = 0; i < PAL_ENTRIES; i++) begin
      hit[i] = pal_used_q[i] && (pal_color_q[i] == color);
    end
  end

  // lowest matching slot wins
  always_comb begin
    hit_idx = '0;
    for (int i = PAL_ENTRIES - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign found = |hit;
  assign pix   = found ? PIX_W'(hit_idx) : PIX_W'(pal_widx);

  always_comb begin
    ch_d        = ch_q;
    fill_d      = fill_q;
    col_d       = col_q;
    row_d       = row_q;
    ovf_d       = ovf_q;
    plane_d     = plane_q;
    held_we     = 1'b0;
    pal_we      = 1'b0;
    push_o      = 1'b0;
    push_data_o = '0;
    if (accept) begin
      if (in_data_i.kind == KIND_QUERY) begin
        push_o            = 1'b1;
        push_data_o.cmd   = CMD_QUERY;
        push_data_o.color = q_color;
        push_data_o.valid = q_valid;
        push_data_o.ovf   = ovf_q;
      end else if (!ovf_q) begin
        if (ch_q < 2'd2) begin
          held_we = 1'b1;
          ch_d    = ch_q + 2'd1;
        end else begin
          ch_d = '0;
          if (!found && pal_full) begin
            ovf_d           = 1'b1;
            push_o          = 1'b1;
            push_data_o.cmd = CMD_OVF;
            push_data_o.ovf = 1'b1;
          end else begin
            if (!found) begin
              pal_we = 1'b1;
              fill_d = fill_q + FILL_W'(1);
            end
            for (int p = 0; p < PLANES; p++) begin
              plane_d[p] = {plane_q[p][BYTE_W-2:0], pix[p]};
            end
            if (col_q == COL_W'(ROWS - 1)) begin
              col_d              = '0;
              row_d              = row_q + ROW_W'(1);
              push_o             = 1'b1;
              push_data_o.cmd    = (row_q == ROW_W'(ROWS - 1)) ? CMD_ROW_LAST : CMD_ROW;
              push_data_o.row    = row_q;
              push_data_o.planes = plane_d;
            end else begin
              col_d = col_q + COL_W'(1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q       <= '0;
      fill_q     <= '0;
      col_q      <= '0;
      row_q      <= '0;
      ovf_q      <= 1'b0;
      pal_used_q <= '0;
    end else begin
      ch_q   <= ch_d;
      fill_q <= fill_d;
      col_q  <= col_d;
      row_q  <= row_d;
      ovf_q  <= ovf_d;
      if (pal_we) begin
        pal_used_q[pal_widx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    plane_q <= plane_d;
    if (held_we) begin
      held_q[ch_q[0]] <= chan5;
    end
    if (pal_we) begin
      pal_color_q[pal_widx] <= color;
    end
  end

`ifndef SYNTH
  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |=> ovf_q)
    else $error("overflow flag cleared");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(PAL_ENTRIES))
    else $error("palette fill beyond capacity");

  a_no_row_after_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && (push_data_o.cmd == CMD_ROW || push_data_o.cmd == CMD_ROW_LAST) |-> !ovf_q)
    else $error("row pushed after overflow");
`endif

endmodule

`default_nettype wire

[rtl/rtpe_fifo.sv]
`default_nettype none

module rtpe_fifo import rtpe_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire qent_t push_data_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output qent_t      pop_data_o,
  output logic       empty_o
);

  qent_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

  a_no_lost_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");
`endif

endmodule

`default_nettype wire

[rtl/rtpe_back.sv]
`default_nettype none

module rtpe_back import rtpe_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  empty_i,
  input  wire qent_t pop_data_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output out_item_t  out_data_o
);

  bk_state_e                      state_q, state_d;
  qent_t                          cur_q;
  logic [BEAT_W-1:0]              beat_q, beat_d;
  logic [2*BYTE_W-1:0]            bank_q [ROWS];
  logic                           out_valid_q;
  out_item_t                      out_q;
  logic                           load_ok;
  logic                           emit;
  out_item_t                      beat;
  logic [BEAT_W-1:0]              sub;
  logic [ROW_W-1:0]               rsel;

  assign load_ok     = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // tile-end beats walk rows: plane 2 then plane 3 of each row
  assign sub  = beat_q - BEAT_W'(2);
  assign rsel = sub[ROW_W:1];

  always_comb begin
    beat = '0;
    case (cur_q.cmd)
      CMD_QUERY: begin
        beat.out_last       = 1'b1;
        beat.palette_color  = cur_q.color;
        beat.palette_valid  = cur_q.valid;
        beat.color_overflow = cur_q.ovf;
      end
      CMD_OVF: begin
        beat.out_last       = 1'b1;
        beat.color_overflow = 1'b1;
      end
      CMD_ROW, CMD_ROW_LAST: begin
        if (beat_q == BEAT_W'(0)) begin
          beat.out_byte = cur_q.planes[0];
        end else if (beat_q == BEAT_W'(1)) begin
          beat.out_byte = cur_q.planes[1];
          beat.out_last = (cur_q.cmd == CMD_ROW);
        end else begin
          beat.out_byte = sub[0] ? bank_q[rsel][2*BYTE_W-1:BYTE_W] : bank_q[rsel][BYTE_W-1:0];
          beat.out_last = (beat_q == BEAT_W'(BEATS_LAST - 1));
        end
      end
      default: beat = '0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    beat_d  = beat_q;
    pop_o   = 1'b0;
    emit    = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          beat_d  = '0;
          state_d = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (load_ok) begin
          emit   = 1'b1;
          beat_d = beat_q + BEAT_W'(1);
          if (beat.out_last) begin
            state_d = BK_IDLE;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      beat_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      beat_q  <= beat_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= beat;
    end
    if (pop_o) begin
      cur_q <= pop_data_i;
      if (pop_data_i.cmd == CMD_ROW || pop_data_i.cmd == CMD_ROW_LAST) begin
        bank_q[pop_data_i.row] <= {pop_data_i.planes[3], pop_data_i.planes[2]};
      end
    end
  end

`ifndef SYNTH
  a_beat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_EMIT |-> beat_q < BEAT_W'(BEATS_LAST))
    else $error("beat counter ran past tile end");

  a_plane_beat_no_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.out_byte != '0 |-> !out_q.palette_valid && !out_q.color_overflow)
    else $error("plane beat carries palette fields");

  a_emit_needs_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> $past(pop_o) || $past(state_q == BK_EMIT))
    else $error("beat emitted without a command");
`endif

endmodule

`default_nettype wire
